/* design/qpht_pkg.sv */
// Shared types and constants for the quadratic probing hash table
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

	localparam int SIZE_W     = 6;
	localparam int KEY_W      = 31;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 5;
	localparam int KEY_PAD_W  = 32;
	localparam int HASH_DIGIT = 4;
	localparam int HASH_STEPS = KEY_PAD_W / HASH_DIGIT;
	localparam int HCNT_W     = $clog2(HASH_STEPS);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_PRESENT   = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_REMOVED   = 3'd5
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} rsp_t;

	typedef struct packed {
		logic [SIZE_W-1:0] table_size;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic hash_step;
		logic rd;
		logic cmp;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hash_last;
		logic skip;
		logic done;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

/* design/qpht_chan_if.sv */
// Valid/ready channel interface carrying one payload per transfer
`timescale 1ns / 1ps
`default_nettype none

interface qpht_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/qpht_ctrl.sv */
// Request sequencer: hash, probe read/compare loop and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module qpht_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               in_ready,
	input  qpht_pkg::sts_t     st,
	output qpht_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_HASH = 5'b00010,
		S_RD   = 5'b00100,
		S_CMP  = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (st.hash_last) begin
					state_nxt = st.skip ? S_RESP : S_RD;
				end
			end
			S_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = S_CMP;
			end
			S_CMP: begin
				cmd.cmp   = 1'b1;
				state_nxt = st.done ? S_RESP : S_RD;
			end
			S_RESP: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/qpht_dp.sv */
// Datapath: size register, remainder unit, probe arithmetic, slot store, result register
`timescale 1ns / 1ps
`default_nettype none

module qpht_dp #(
	parameter int MAX_SLOTS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  qpht_pkg::cmd_t          cmd,
	output qpht_pkg::sts_t          st,
	input  qpht_pkg::req_t          req_data,
	input  wire logic               cfg_we,
	input  qpht_pkg::cfg_t          cfg_data,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output qpht_pkg::rsp_t          rsp_data
);

	localparam int SW       = qpht_pkg::SIZE_W;
	localparam int DEPTH    = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int LIVE_MAX = (MAX_SLOTS < 63) ? MAX_SLOTS : 63;
	localparam int RESET_N  = (31 > LIVE_MAX) ? LIVE_MAX : 31;

	function automatic logic [SW-1:0] mod_add(input logic [SW-1:0] a,
	                                          input logic [SW-1:0] b,
	                                          input logic [SW-1:0] m);
		logic [SW:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[SW-1:0];
	endfunction

	logic [SW-1:0]                   n_q;
	logic [SW-1:0]                   count_q;
	logic [DEPTH-1:0]                used_q;
	logic                            rsp_valid_q;
	qpht_pkg::rsp_t                  rsp_q;

	logic [qpht_pkg::HCNT_W-1:0]     hcnt_q;
	logic [qpht_pkg::KEY_PAD_W-1:0]  kshift_q;
	logic [SW-1:0]                   rem_q;
	logic [SW-1:0]                   s_q;
	logic [SW-1:0]                   inc_q;
	logic [SW-1:0]                   delta_q;
	logic [SW-1:0]                   i_q;
	logic [qpht_pkg::OP_W-1:0]       op_q;
	logic [qpht_pkg::KEY_W-1:0]      key_q;
	logic [qpht_pkg::KEY_W-1:0]      rd_key_q;
	qpht_pkg::rsp_t                  res_q;
	logic [qpht_pkg::KEY_W-1:0]      key_mem [DEPTH];

	logic [SW-1:0]                   rem_nxt;
	logic [SW-1:0]                   n_live;
	logic [SW-1:0]                   one_mod;
	logic [SW-1:0]                   three_mod;
	logic [IDX_W-1:0]                s_idx;
	logic                            is_ins, is_srch, is_rem;
	logic                            used_bit, hit, last_probe, done, skip;
	logic                            ins_we, rem_we;
	qpht_pkg::rsp_t                  res_cmp;
	qpht_pkg::rsp_t                  res_miss;

	// radix-16 remainder step: four restoring steps on the narrow remainder
	always_comb begin
		logic [SW:0]   t;
		logic [SW-1:0] r;
		r = rem_q;
		for (int b = 0; b < qpht_pkg::HASH_DIGIT; b++) begin
			t = {r, kshift_q[qpht_pkg::KEY_PAD_W-1-b]};
			if (t >= {1'b0, n_q}) begin
				t = t - {1'b0, n_q};
			end
			r = t[SW-1:0];
		end
		rem_nxt = r;
	end

	always_comb begin
		if (cfg_data.table_size == '0) begin
			n_live = SW'(1);
		end else if (cfg_data.table_size > SW'(LIVE_MAX)) begin
			n_live = SW'(LIVE_MAX);
		end else begin
			n_live = cfg_data.table_size;
		end
	end

	assign one_mod   = mod_add('0, SW'(1), n_q);
	assign three_mod = mod_add(mod_add(one_mod, SW'(1), n_q), SW'(1), n_q);

	assign s_idx      = s_q[IDX_W-1:0];
	assign is_ins     = (op_q == qpht_pkg::OP_INSERT);
	assign is_srch    = (op_q == qpht_pkg::OP_SEARCH);
	assign is_rem     = (op_q == qpht_pkg::OP_REMOVE);
	assign used_bit   = used_q[s_idx];
	assign hit        = used_bit && (rd_key_q == key_q);
	assign last_probe = (i_q == (n_q - SW'(1)));
	assign done       = hit || (is_ins && !used_bit) || last_probe;
	assign skip       = (is_ins && (count_q >= n_q)) || !(is_ins || is_srch || is_rem);

	always_comb begin
		res_miss.status = is_ins ? qpht_pkg::ST_FULL : qpht_pkg::ST_NOT_FOUND;
		res_miss.slot   = '0;
		ins_we          = 1'b0;
		rem_we          = 1'b0;
		res_cmp         = res_miss;
		if (hit) begin
			res_cmp.slot = qpht_pkg::SLOT_W'(s_q);
			if (is_ins) begin
				res_cmp.status = qpht_pkg::ST_PRESENT;
			end else if (is_srch) begin
				res_cmp.status = qpht_pkg::ST_FOUND;
			end else begin
				res_cmp.status = qpht_pkg::ST_REMOVED;
				rem_we         = cmd.cmp;
			end
		end else if (is_ins && !used_bit) begin
			res_cmp.status = qpht_pkg::ST_INSERTED;
			res_cmp.slot   = qpht_pkg::SLOT_W'(s_q);
			ins_we         = cmd.cmp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= SW'(RESET_N);
			count_q     <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				n_q     <= n_live;
				count_q <= '0;
				used_q  <= '0;
			end else if (ins_we) begin
				count_q       <= count_q + SW'(1);
				used_q[s_idx] <= 1'b1;
			end else if (rem_we) begin
				if (count_q != '0) begin
					count_q <= count_q - SW'(1);
				end
				used_q[s_idx] <= 1'b0;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req_data.op;
			key_q    <= req_data.key;
			kshift_q <= {1'b0, req_data.key};
			rem_q    <= '0;
			hcnt_q   <= '0;
		end
		if (cmd.hash_step) begin
			kshift_q <= kshift_q << qpht_pkg::HASH_DIGIT;
			rem_q    <= rem_nxt;
			hcnt_q   <= hcnt_q + qpht_pkg::HCNT_W'(1);
			if (st.hash_last) begin
				s_q     <= rem_nxt;
				inc_q   <= one_mod;
				delta_q <= three_mod;
				i_q     <= '0;
				res_q   <= res_miss;
			end
		end
		if (cmd.cmp) begin
			res_q   <= res_cmp;
			s_q     <= done ? s_q : mod_add(s_q, inc_q, n_q);
			inc_q   <= mod_add(inc_q, delta_q, n_q);
			delta_q <= mod_add(mod_add(delta_q, SW'(1), n_q), SW'(1), n_q);
			i_q     <= i_q + SW'(1);
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	// slot key store: read in the probe read cycle, written on insert
	always_ff @(posedge clk) begin
		if (ins_we) begin
			key_mem[s_idx] <= key_q;
		end
		if (cmd.rd) begin
			rd_key_q <= key_mem[s_idx];
		end
	end

	assign st.hash_last = (hcnt_q == qpht_pkg::HCNT_W'(qpht_pkg::HASH_STEPS - 1));
	assign st.skip      = skip;
	assign st.done      = done;
	assign st.out_busy  = rsp_valid_q && !rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

/* design/quadratic_probe_hash_table.sv */
// Top level of the quadratic probing hash set
// One request is worked at a time. After the request transfer the key is
// reduced modulo the table size by a remainder unit taking four key bits a
// cycle; each probe then reads the slot key store and then compares and steps
// the probe. A request that probes no slots (an insert into a full table or
// the unused op code) skips the probe loop; a result is placed in the output
// register only once the previous result is no longer waiting there, and the
// next request is taken the cycle after the result is placed in the output
// register. Writing table_size empties the table at once; no clearing pass
// is needed.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table #(
	parameter int MAX_SLOTS = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	qpht_chan_if.sink   req,
	qpht_chan_if.source rsp,
	qpht_chan_if.sink   cfg
);

	qpht_pkg::cmd_t cmd;
	qpht_pkg::sts_t st;
	logic           in_ready;

	qpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.in_ready  (in_ready),
		.st        (st),
		.cmd       (cmd)
	);

	qpht_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req_data  (req.data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

endmodule

`default_nettype wire

/* design/qpht_chk.sv */
// Port-level checker for the hash set, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module qpht_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input qpht_pkg::rsp_t      rsp_data
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status <= qpht_pkg::ST_REMOVED))
		else $error("result status out of range");

	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.status == qpht_pkg::ST_FULL ||
		               rsp_data.status == qpht_pkg::ST_NOT_FOUND))
		|-> (rsp_data.slot == '0))
		else $error("miss result carries a non-zero slot");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled result changed");

endmodule

bind quadratic_probe_hash_table qpht_chk u_qpht_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

/* bench/tb_quadratic_probe_hash_table.sv */
// Testbench for the quadratic probing hash set: directed table, then random phases
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;

	localparam int MAX_SLOTS       = 32;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int SETTLE_CYCLES   = 24;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam logic [qpht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                          cfg_row;
		logic [qpht_pkg::SIZE_W-1:0]   size;
		logic [qpht_pkg::OP_W-1:0]     op;
		logic [qpht_pkg::KEY_W-1:0]    key;
		logic                          typed;
		qpht_pkg::status_t             status;
		logic [qpht_pkg::SLOT_W-1:0]   slot;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	qpht_chan_if #(.T(qpht_pkg::req_t)) req_if ();
	qpht_chan_if #(.T(qpht_pkg::rsp_t)) rsp_if ();
	qpht_chan_if #(.T(qpht_pkg::cfg_t)) cfg_if ();

	quadratic_probe_hash_table #(.MAX_SLOTS(MAX_SLOTS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// mirror of the table
	logic [qpht_pkg::SIZE_W-1:0] tbl_size = 6'd31;
	bit                          slot_taken [MAX_SLOTS];
	logic [qpht_pkg::KEY_W-1:0]  slot_holds [MAX_SLOTS];
	int unsigned                 stored = 0;

	qpht_pkg::rsp_t due_results [$];
	qpht_pkg::rsp_t owed;
	int unsigned    mismatches = 0;
	int unsigned    cycles = 0;
	int unsigned    src_idle_pct = 0;
	int unsigned    snk_stall_pct = 0;

	logic [qpht_pkg::KEY_W-1:0]  key_pool [40];
	logic [qpht_pkg::SIZE_W-1:0] phase_sizes [12] = '{6'd32, 6'd1, 6'd2, 6'd5, 6'd17,
		6'd31, 6'd0, 6'd63, 6'd7, 6'd3, 6'd33, 6'd16};

	// cfg_row, size, op, key, typed, status, slot
	step_t script [28] = '{
		'{1'b0, 6'd0, qpht_pkg::OP_SEARCH, 31'd5, 1'b1, qpht_pkg::ST_NOT_FOUND, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_REMOVE, 31'd7, 1'b1, qpht_pkg::ST_NOT_FOUND, 5'd0},
		'{1'b0, 6'd0, OP_UNUSED, 31'h7FFFFFFF, 1'b1, qpht_pkg::ST_NOT_FOUND, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd0, 1'b1, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'h7FFFFFFF, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd0, 1'b1, qpht_pkg::ST_PRESENT, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd31, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd62, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_SEARCH, 31'd31, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_REMOVE, 31'd0, 1'b1, qpht_pkg::ST_REMOVED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_SEARCH, 31'd31, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_SEARCH, 31'd0, 1'b1, qpht_pkg::ST_NOT_FOUND, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_REMOVE, 31'd31, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_REMOVE, 31'd31, 1'b1, qpht_pkg::ST_NOT_FOUND, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'h2AAAAAAA, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_SEARCH, 31'h55555555, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b1, 6'd1, qpht_pkg::OP_INSERT, 31'd0, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd9, 1'b1, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd10, 1'b1, qpht_pkg::ST_FULL, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd9, 1'b1, qpht_pkg::ST_FULL, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_SEARCH, 31'd9, 1'b1, qpht_pkg::ST_FOUND, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_REMOVE, 31'd9, 1'b1, qpht_pkg::ST_REMOVED, 5'd0},
		'{1'b1, 6'd0, qpht_pkg::OP_INSERT, 31'd0, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd3, 1'b1, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b1, 6'd63, qpht_pkg::OP_INSERT, 31'd0, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'd32, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_INSERT, 31'h7FFFFFFF, 1'b0, qpht_pkg::ST_INSERTED, 5'd0},
		'{1'b0, 6'd0, qpht_pkg::OP_SEARCH, 31'd3, 1'b1, qpht_pkg::ST_NOT_FOUND, 5'd0}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned live_slots();
		if (tbl_size == 0)
			return 1;
		if (tbl_size > MAX_SLOTS)
			return MAX_SLOTS;
		return 32'(tbl_size);
	endfunction

	function automatic qpht_pkg::rsp_t apply_request(input logic [qpht_pkg::OP_W-1:0] op,
			input logic [qpht_pkg::KEY_W-1:0] key);
		int unsigned    n;
		int unsigned    s;
		int unsigned    at;
		bit             hit;
		bit             stop;
		qpht_pkg::rsp_t r;
		n = live_slots();
		s = key % n;
		at = 0;
		hit = 1'b0;
		stop = 1'b0;
		// search and remove walk past empty slots, insert stops at the first one
		for (int unsigned i = 0; i < n && !stop; i++) begin
			if (slot_taken[s] && slot_holds[s] == key) begin
				hit = 1'b1;
				stop = 1'b1;
				at = s;
			end else if (op == qpht_pkg::OP_INSERT && !slot_taken[s]) begin
				stop = 1'b1;
				at = s;
			end else begin
				s = (s + (i + 1) * (i + 1)) % n;
			end
		end
		r = '{status: qpht_pkg::ST_NOT_FOUND, slot: '0};
		case (op)
			qpht_pkg::OP_INSERT: begin
				if (stored >= n || !stop) begin
					r.status = qpht_pkg::ST_FULL;
				end else if (hit) begin
					r = '{status: qpht_pkg::ST_PRESENT, slot: qpht_pkg::SLOT_W'(at)};
				end else begin
					slot_taken[at] = 1'b1;
					slot_holds[at] = key;
					stored++;
					r = '{status: qpht_pkg::ST_INSERTED, slot: qpht_pkg::SLOT_W'(at)};
				end
			end
			qpht_pkg::OP_SEARCH: begin
				if (hit)
					r = '{status: qpht_pkg::ST_FOUND, slot: qpht_pkg::SLOT_W'(at)};
			end
			qpht_pkg::OP_REMOVE: begin
				if (hit) begin
					slot_taken[at] = 1'b0;
					if (stored > 0)
						stored--;
					r = '{status: qpht_pkg::ST_REMOVED, slot: qpht_pkg::SLOT_W'(at)};
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic set_idling(input int unsigned mode);
		case (mode)
			0: begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end
			1: begin
				src_idle_pct = 48;
				snk_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				snk_stall_pct = 48;
			end
			default: begin
				src_idle_pct = 13;
				snk_stall_pct = 13;
			end
		endcase
	endtask

	task automatic put_request(input logic [qpht_pkg::OP_W-1:0] op,
			input logic [qpht_pkg::KEY_W-1:0] key,
			input logic typed, input qpht_pkg::rsp_t given);
		qpht_pkg::rsp_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= '{op: op, key: key};
		do @(posedge clk); while (!req_if.ready);
		predicted = apply_request(op, key);
		due_results.push_back(typed ? given : predicted);
	endtask

	task automatic settle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_table_size(input logic [qpht_pkg::SIZE_W-1:0] sz);
		settle();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{table_size: sz};
		do @(posedge clk); while (!cfg_if.ready);
		// a size write empties the table
		tbl_size = sz;
		stored = 0;
		foreach (slot_taken[k])
			slot_taken[k] = 1'b0;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	always @(negedge clk)
		rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d slot %0d",
					$time, rsp_if.data.status, rsp_if.data.slot);
				mismatches++;
			end else begin
				owed = due_results.pop_front();
				if (rsp_if.data.status !== owed.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, owed.status, rsp_if.data.status);
					mismatches++;
				end
				if (rsp_if.data.slot !== owed.slot) begin
					$display("%0t: slot mismatch, expected %0d, actual %0d",
						$time, owed.slot, rsp_if.data.slot);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned                 n;
		int unsigned                 pool_top;
		int unsigned                 roll;
		int unsigned                 insert_top;
		logic [qpht_pkg::OP_W-1:0]   op;
		logic [qpht_pkg::KEY_W-1:0]  key;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		foreach (slot_taken[k])
			slot_taken[k] = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idling(0);
		foreach (script[r]) begin
			if (script[r].cfg_row)
				write_table_size(script[r].size);
			else
				put_request(script[r].op, script[r].key, script[r].typed,
					'{status: script[r].status, slot: script[r].slot});
		end

		foreach (phase_sizes[ph]) begin
			write_table_size(phase_sizes[ph]);
			set_idling(ph % 4);
			n = live_slots();
			pool_top = (2 * n + 1 < 39) ? 2 * n + 1 : 39;
			// colliding small keys mixed with wide ones
			foreach (key_pool[k])
				key_pool[k] = $urandom_range(0, 1)
					? qpht_pkg::KEY_W'($urandom_range(0, 3 * n))
					: qpht_pkg::KEY_W'($urandom);
			for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
				// fill early in the phase, drain later
				insert_top = (it < ITEMS_PER_PHASE / 2) ? 60 : 35;
				roll = $urandom_range(0, 99);
				if (roll < 3)
					op = OP_UNUSED;
				else if (roll < insert_top)
					op = qpht_pkg::OP_INSERT;
				else if (roll < 70)
					op = qpht_pkg::OP_SEARCH;
				else
					op = qpht_pkg::OP_REMOVE;
				if ($urandom_range(0, 9) < 8)
					key = key_pool[$urandom_range(0, pool_top)];
				else
					key = qpht_pkg::KEY_W'($urandom);
				put_request(op, key, 1'b0, '0);
			end
		end

		settle();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
